### hdl/lssd_pkg.sv
package lssd_pkg;

  // Field widths fixed by the script word format
  localparam int CODE_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int INDEX_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int SKIP_SUM_W = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_END      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_END_ALL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_END_LAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SKIP     = 3'd4;

  // Configuration reset values
  localparam logic [COUNT_W-1:0] RST_LED_COUNT     = 7'd64;
  localparam logic [CODE_W-1:0]  RST_CODE_END      = 8'hFF;
  localparam logic [CODE_W-1:0]  RST_CODE_END_ALL  = 8'hFE;
  localparam logic [CODE_W-1:0]  RST_CODE_END_LAST = 8'hFD;
  localparam logic [CODE_W-1:0]  RST_CODE_SKIP     = 8'hFC;

  typedef struct packed {
    logic               first_word;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               write_enable;
    logic               last;
    logic               scene_done;
  } out_item_t;

  // One stored script word
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [CODE_W-1:0]  code;
  } script_word_t;

  typedef enum logic [2:0] {
    CLS_END  = 3'd0,
    CLS_ALL  = 3'd1,
    CLS_LAST = 3'd2,
    CLS_SKIP = 3'd3,
    CLS_RUN  = 3'd4
  } code_class_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic sel_rdata;
    logic store_word;
    logic load_run;
    logic emit;
    logic deactivate;
    logic pass_start;
    logic next_word;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic        active;
    logic        full;
    code_class_t cls;
    logic        run_done;
    logic        emit_ok;
    logic        final_ok;
    logic        can_replay;
    logic        more_words;
    logic        pass_stalled;
  } dp_status_t;

endpackage

### hdl/led_scene_script_decoder_core.sv
// LED scene script decoder.
// Input channel (in_valid/in_ready/in_data) takes one scene script word: a
// code byte and an RGB colour, with first_word opening a new scene. The
// result channel (out_valid/out_ready/out_data) gives LED colour writes, and
// for a word that writes nothing one status-only item; the final item of a
// word carries last, and scene_done when the scene has ended.
// The cfg port (cfg_we/cfg_index/cfg_data) sets the strip length and the
// special codes; write it only while the block is idle.
// Steps: a word that writes LEDs is decoded, its writes are issued, and a
// finish step then hands its final item to the output register; an end code
// or a word for an ended scene goes from decode to finish, then back to idle.
// Each stored word replayed by the end-all code goes through store read,
// decode, run end and a next-word check plus its writes, and each pass ends
// with a pass check. The store read is registered; the write loop writes one LED per cycle unless stalled.
// A new word is accepted only after the previous word's final item has been
// handed to the output register, which may still be waiting for out_ready.
// A stalled receiver holds the write loop once the output register and the
// one-deep hold-back register are full; nothing is dropped.
// Reset clears the configuration to its defaults and ends any scene; the
// script store is not cleared and needs no reset pass.
module led_scene_script_decoder_core #(
  parameter int MAX_LEDS     = 64,
  parameter int SCRIPT_WORDS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lssd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lssd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lssd_pkg::out_item_t             out_data
);

  lssd_pkg::dp_cmd_t    cmd;
  lssd_pkg::dp_status_t sts;

  lssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lssd_dp #(
    .MAX_LEDS     (MAX_LEDS),
    .SCRIPT_WORDS (SCRIPT_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hdl/lssd_ctrl.sv
module lssd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lssd_pkg::dp_status_t sts,
  output lssd_pkg::dp_cmd_t   cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_EXEC     = 8'b0000_0010,
    ST_RUN      = 8'b0000_0100,
    ST_RPL_ADDR = 8'b0000_1000,
    ST_RPL_EXEC = 8'b0001_0000,
    ST_RPL_NEXT = 8'b0010_0000,
    ST_RPL_PASS = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   rpl_r, rpl_nxt;

  // Hold state and replay flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rpl_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rpl_r   <= rpl_nxt;
    end
  end

  // Sequence one script word through decode, runs and replay passes
  always_comb begin
    state_nxt = state_r;
    rpl_nxt   = rpl_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rpl_nxt  = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.active || sts.full) begin
          cmd.deactivate = 1'b1;
          state_nxt      = ST_FINISH;
        end else begin
          case (sts.cls)
            lssd_pkg::CLS_END: begin
              cmd.deactivate = 1'b1;
              state_nxt      = ST_FINISH;
            end
            lssd_pkg::CLS_ALL: begin
              if (sts.can_replay) begin
                cmd.pass_start = 1'b1;
                rpl_nxt        = 1'b1;
                state_nxt      = ST_RPL_ADDR;
              end else begin
                cmd.deactivate = 1'b1;
                state_nxt      = ST_FINISH;
              end
            end
            default: begin
              cmd.store_word = 1'b1;
              cmd.load_run   = 1'b1;
              state_nxt      = ST_RUN;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (sts.run_done) begin
          if (rpl_r) begin
            state_nxt = ST_RPL_NEXT;
          end else begin
            cmd.deactivate = sts.full;
            state_nxt      = ST_FINISH;
          end
        end else if (sts.emit_ok) begin
          cmd.emit = 1'b1;
        end
      end
      ST_RPL_ADDR: begin
        // wait for the store read
        state_nxt = ST_RPL_EXEC;
      end
      ST_RPL_EXEC: begin
        cmd.sel_rdata = 1'b1;
        case (sts.cls)
          lssd_pkg::CLS_END: begin
            cmd.deactivate = 1'b1;
            state_nxt      = ST_FINISH;
          end
          lssd_pkg::CLS_ALL: begin
            state_nxt = ST_RPL_PASS;
          end
          default: begin
            cmd.load_run = 1'b1;
            state_nxt    = ST_RUN;
          end
        endcase
      end
      ST_RPL_NEXT: begin
        if (sts.full) begin
          cmd.deactivate = 1'b1;
          state_nxt      = ST_FINISH;
        end else if (sts.more_words) begin
          cmd.next_word = 1'b1;
          state_nxt     = ST_RPL_ADDR;
        end else begin
          state_nxt = ST_RPL_PASS;
        end
      end
      ST_RPL_PASS: begin
        // a pass that moved nothing ends the replay
        if (sts.pass_stalled) begin
          cmd.deactivate = 1'b1;
          state_nxt      = ST_FINISH;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = ST_RPL_ADDR;
        end
      end
      ST_FINISH: begin
        if (sts.final_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/lssd_dp.sv
module lssd_dp #(
  parameter int MAX_LEDS     = 64,
  parameter int SCRIPT_WORDS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lssd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lssd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  lssd_pkg::in_item_t                    in_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output lssd_pkg::out_item_t                   out_data,
  input  lssd_pkg::dp_cmd_t                     cmd,
  output lssd_pkg::dp_status_t                  sts
);

  localparam int PTR_W = $clog2(SCRIPT_WORDS + 1);
  localparam int IDX_W = $clog2(SCRIPT_WORDS);
  localparam int CW    = lssd_pkg::COUNT_W;

  // Configuration
  logic [CW-1:0]                   led_count_r;
  logic [lssd_pkg::CODE_W-1:0]     code_end_r;
  logic [lssd_pkg::CODE_W-1:0]     code_end_all_r;
  logic [lssd_pkg::CODE_W-1:0]     code_end_last_r;
  logic [lssd_pkg::CODE_W-1:0]     code_skip_r;

  // Scene state
  logic [CW-1:0]                   pos_r;
  logic [PTR_W-1:0]                ptr_r;
  logic                            active_r;
  logic                            ovf_r;

  // Run and replay state
  lssd_pkg::script_word_t          word_r;
  lssd_pkg::script_word_t          rdata_r;
  logic [lssd_pkg::CODE_W-1:0]     k_r;
  logic                            fill_r;
  logic [CW-1:0]                   start_r;
  logic [IDX_W-1:0]                rd_idx_r;

  // Result staging: one write held back so the final one can carry last
  logic                            pend_v_r;
  lssd_pkg::out_item_t             pend_r;
  logic                            out_v_r;
  lssd_pkg::out_item_t             out_r;

  lssd_pkg::script_word_t          store_mem [SCRIPT_WORDS];

  logic [CW-1:0]                   strip_len;
  lssd_pkg::script_word_t          src;
  lssd_pkg::code_class_t           cls;
  logic [lssd_pkg::SKIP_SUM_W-1:0] skip_sum;
  logic [CW-1:0]                   skip_pos;
  logic                            full;
  logic                            slot_free;
  logic                            emit_ok;
  lssd_pkg::out_item_t             wr_item;
  lssd_pkg::out_item_t             final_item;

  // Clamp the strip length to the build limit
  assign strip_len = (led_count_r > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : led_count_r;
  assign full      = (pos_r >= strip_len);

  // Classify the word being decoded; end has top priority
  assign src = cmd.sel_rdata ? rdata_r : word_r;
  always_comb begin
    if (src.code == code_end_r) begin
      cls = lssd_pkg::CLS_END;
    end else if (src.code == code_end_all_r) begin
      cls = lssd_pkg::CLS_ALL;
    end else if (src.code == code_end_last_r) begin
      cls = lssd_pkg::CLS_LAST;
    end else if (src.code == code_skip_r) begin
      cls = lssd_pkg::CLS_SKIP;
    end else begin
      cls = lssd_pkg::CLS_RUN;
    end
  end

  // Saturate a skip at the strip end
  assign skip_sum = lssd_pkg::SKIP_SUM_W'(pos_r) + lssd_pkg::SKIP_SUM_W'(src.red);
  assign skip_pos = (skip_sum > lssd_pkg::SKIP_SUM_W'(strip_len)) ? strip_len
                                                                 : skip_sum[CW-1:0];

  assign slot_free = !out_v_r || out_ready;
  assign emit_ok   = !pend_v_r || slot_free;

  always_comb begin
    wr_item              = '0;
    wr_item.led_index    = pos_r[lssd_pkg::INDEX_W-1:0];
    wr_item.out_red      = word_r.red;
    wr_item.out_green    = word_r.green;
    wr_item.out_blue     = word_r.blue;
    wr_item.write_enable = 1'b1;
  end

  always_comb begin
    final_item            = pend_v_r ? pend_r : '0;
    final_item.last       = 1'b1;
    final_item.scene_done = !active_r;
  end

  // Status to the controller
  always_comb begin
    sts              = '0;
    sts.active       = active_r;
    sts.full         = full;
    sts.cls          = cls;
    sts.run_done     = full || (!fill_r && (k_r == '0));
    sts.emit_ok      = emit_ok;
    sts.final_ok     = slot_free;
    sts.can_replay   = (ptr_r != '0) && !ovf_r;
    sts.more_words   = ((PTR_W'(rd_idx_r) + PTR_W'(1)) < ptr_r);
    sts.pass_stalled = (pos_r == start_r);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r     <= lssd_pkg::RST_LED_COUNT;
      code_end_r      <= lssd_pkg::RST_CODE_END;
      code_end_all_r  <= lssd_pkg::RST_CODE_END_ALL;
      code_end_last_r <= lssd_pkg::RST_CODE_END_LAST;
      code_skip_r     <= lssd_pkg::RST_CODE_SKIP;
    end else if (cfg_we) begin
      case (cfg_index)
        lssd_pkg::CFG_LED_COUNT:     led_count_r     <= cfg_data[CW-1:0];
        lssd_pkg::CFG_CODE_END:      code_end_r      <= cfg_data;
        lssd_pkg::CFG_CODE_END_ALL:  code_end_all_r  <= cfg_data;
        lssd_pkg::CFG_CODE_END_LAST: code_end_last_r <= cfg_data;
        lssd_pkg::CFG_CODE_SKIP:     code_skip_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scene control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ptr_r    <= '0;
      active_r <= 1'b0;
      ovf_r    <= 1'b0;
      k_r      <= '0;
      fill_r   <= 1'b0;
      start_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      // restart the scene on a first word
      if (cmd.load_in && in_data.first_word) begin
        pos_r    <= '0;
        ptr_r    <= '0;
        ovf_r    <= 1'b0;
        active_r <= 1'b1;
      end
      if (cmd.deactivate) begin
        active_r <= 1'b0;
      end
      // append to the store, or flag overflow
      if (cmd.store_word) begin
        if (ptr_r < PTR_W'(SCRIPT_WORDS)) begin
          ptr_r <= ptr_r + PTR_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // set up a run; a skip moves the position at once
      if (cmd.load_run) begin
        fill_r <= (cls == lssd_pkg::CLS_LAST);
        if (cls == lssd_pkg::CLS_RUN) begin
          k_r <= (src.code == '0) ? lssd_pkg::CODE_W'(1) : src.code;
        end else begin
          k_r <= '0;
        end
        if (cls == lssd_pkg::CLS_SKIP) begin
          pos_r <= skip_pos;
        end
      end
      // advance one LED per write
      if (cmd.emit) begin
        pos_r <= pos_r + CW'(1);
        if (!fill_r) begin
          k_r <= k_r - lssd_pkg::CODE_W'(1);
        end
      end
      if (cmd.pass_start) begin
        start_r  <= pos_r;
        rd_idx_r <= '0;
      end else if (cmd.next_word) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  // Current word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      word_r.code  <= in_data.code;
      word_r.red   <= in_data.red;
      word_r.green <= in_data.green;
      word_r.blue  <= in_data.blue;
    end else if (cmd.load_run && cmd.sel_rdata) begin
      word_r <= rdata_r;
    end
  end

  // Script store
  always_ff @(posedge clk) begin
    if (cmd.store_word && (ptr_r < PTR_W'(SCRIPT_WORDS))) begin
      store_mem[ptr_r[IDX_W-1:0]] <= word_r;
    end
    rdata_r <= store_mem[rd_idx_r];
  end

  // Result staging valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          out_v_r <= 1'b1;
        end else if (out_v_r && out_ready) begin
          out_v_r <= 1'b0;
        end
      end else if (cmd.finish) begin
        pend_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end else if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Result staging payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_r <= wr_item;
      if (pend_v_r) begin
        out_r <= pend_r;
      end
    end else if (cmd.finish) begin
      out_r <= final_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
